[design/rpn_stack_calculator_core_defines.svh]
`ifndef RPN_STACK_CALCULATOR_CORE_DEFINES_SVH
`define RPN_STACK_CALCULATOR_CORE_DEFINES_SVH

// same-cycle implication on clk_i, off during reset
`define RPN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rpn core: same-cycle check failed");

// next-cycle implication on clk_i, off during reset
`define RPN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpn core: next-cycle check failed");

`endif

[design/rpn_pkg.sv]
`default_nettype none

package rpn_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned DEPTH_W     = 7;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_DUP  = 3'd1,
    CMD_ABS  = 3'd2,
    CMD_ADD  = 3'd3,
    CMD_SUB  = 3'd4,
    CMD_MUL  = 3'd5,
    CMD_DIV  = 3'd6,
    CMD_MOD  = 3'd7
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_UNF  = 2'd1,
    ST_OVF  = 2'd2,
    ST_DIVZ = 2'd3
  } status_e;

  typedef logic [DATA_W-1:0] word_t;

  function automatic word_t magnitude(input word_t x);
    magnitude = x[DATA_W-1] ? word_t'(-x) : x;
  endfunction

endpackage

`default_nettype wire

[design/rpn_if.sv]
`default_nettype none

interface rpn_cmd_if;
  import rpn_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface rpn_res_if;
  import rpn_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top_value;
  logic [DEPTH_W-1:0]       depth;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, top_value, depth, status, input ready);
  modport sink   (input valid, top_value, depth, status, output ready);
endinterface

`default_nettype wire

[design/rpn_div.sv]
`default_nettype none

module rpn_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  is_mod_i,
  input  rpn_pkg::word_t        dividend_i,
  input  rpn_pkg::word_t        divisor_i,
  output logic                  done_o,
  output rpn_pkg::word_t        result_o
);
  import rpn_pkg::*;

  localparam int unsigned STEP_W = $clog2(DATA_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  word_t             rem_q, quo_q, ub_q;
  logic              is_mod_q, quo_neg_q, rem_neg_q;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign diff    = shifted - {1'b0, ub_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = '0;
    end else if (busy_q) begin
      step_d = step_q + STEP_W'(1);
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quo_q     <= magnitude(dividend_i);
      ub_q      <= magnitude(divisor_i);
      is_mod_q  <= is_mod_i;
      quo_neg_q <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
      rem_neg_q <= dividend_i[DATA_W-1];
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_q <= diff[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (is_mod_q) begin
      result_o = rem_neg_q ? word_t'(-rem_q) : rem_q;
    end else begin
      result_o = quo_neg_q ? word_t'(-quo_q) : quo_q;
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

[design/rpn_stack_calculator_core.sv]
// RPN stack calculator on 32-bit signed integers. Each input item carries one
// operation (push, dup, abs, add, sub, mul, div, mod) and yields exactly one
// result item with the new top of stack (zero when empty), the depth and a
// status; underflow, overflow and divide by zero leave the stack unchanged.
// The stack sits in a 64 x 32 memory with two registered read ports and one
// write port. Push, dup, abs, add, sub and mul read the two top entries when
// the item is taken, then compute and write back once the output register is
// free. Div and mod run on in the radix-2 divider, which retires one quotient
// bit per cycle; a div or mod that underflows or hits a zero divisor finishes
// as the others do. A new item is taken while the previous result waits at
// the output register. The memory needs no clearing after reset.
`default_nettype none

module rpn_stack_calculator_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  rpn_cmd_if.sink   req_i,
  rpn_res_if.source res_o
);
  import rpn_pkg::*;

  `include "rpn_stack_calculator_core_defines.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;

  word_t            mem [STACK_DEPTH];
  word_t            rd_a_q, rd_b_q;
  logic [CMD_W-1:0] cmd_q;
  word_t            value_q;

  word_t              top_out_q;
  logic [DEPTH_W-1:0] depth_out_q;
  logic [STATUS_W-1:0] status_out_q;

  logic             accept, out_free, finish;
  logic [CNT_W-1:0] cnt_m1, cnt_m2;
  logic             empty, full, lt2;

  status_e          st;
  logic             wr_req, wr_en, div_go, div_start, div_done;
  logic [ADDR_W-1:0] wr_addr;
  word_t            wr_data, top_res, mul_res, div_res;

  assign cnt_m1 = count_q - CNT_W'(1);
  assign cnt_m2 = count_q - CNT_W'(2);
  assign empty  = (count_q == '0);
  assign full   = (count_q == FULL_CNT);
  assign lt2    = (count_q < CNT_W'(2));

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_a_q <= mem[cnt_m2[ADDR_W-1:0]];
      rd_b_q <= mem[cnt_m1[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= req_i.cmd;
      value_q <= word_t'(req_i.value);
    end
  end

  assign mul_res = rd_a_q * rd_b_q;

  always_comb begin
    st      = ST_OK;
    wr_req  = 1'b0;
    wr_addr = count_q[ADDR_W-1:0];
    wr_data = value_q;
    count_d = count_q;
    top_res = empty ? '0 : rd_b_q;
    div_go  = 1'b0;
    case (cmd_q)
      CMD_PUSH: begin
        if (full) begin
          st = ST_OVF;
        end else begin
          wr_req  = 1'b1;
          count_d = count_q + CNT_W'(1);
          top_res = value_q;
        end
      end
      CMD_DUP: begin
        if (empty) begin
          st = ST_UNF;
        end else if (full) begin
          st = ST_OVF;
        end else begin
          wr_req  = 1'b1;
          wr_data = rd_b_q;
          count_d = count_q + CNT_W'(1);
          top_res = rd_b_q;
        end
      end
      CMD_ABS: begin
        if (empty) begin
          st = ST_UNF;
        end else begin
          wr_req  = 1'b1;
          wr_addr = cnt_m1[ADDR_W-1:0];
          wr_data = magnitude(rd_b_q);
          top_res = magnitude(rd_b_q);
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL: begin
        if (lt2) begin
          st = ST_UNF;
        end else begin
          wr_req  = 1'b1;
          wr_addr = cnt_m2[ADDR_W-1:0];
          count_d = cnt_m1;
          case (cmd_q)
            CMD_ADD: wr_data = rd_a_q + rd_b_q;
            CMD_SUB: wr_data = rd_a_q - rd_b_q;
            default: wr_data = mul_res;
          endcase
          top_res = wr_data;
        end
      end
      CMD_DIV, CMD_MOD: begin
        if (lt2) begin
          st = ST_UNF;
        end else if (rd_b_q == '0) begin
          st = ST_DIVZ;
        end else begin
          div_go = 1'b1;
        end
      end
      default: ;
    endcase
    if (state_q == S_DIV) begin
      st      = ST_OK;
      wr_req  = 1'b1;
      wr_addr = cnt_m2[ADDR_W-1:0];
      wr_data = div_res;
      count_d = cnt_m1;
      top_res = div_res;
    end
  end

  assign div_start = (state_q == S_EXEC) && div_go;
  assign finish    = (((state_q == S_EXEC) && !div_go) || ((state_q == S_DIV) && div_done))
                     && out_free;
  assign wr_en     = finish && wr_req;

  rpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .is_mod_i   (cmd_q == CMD_MOD),
    .dividend_i (rd_a_q),
    .divisor_i  (rd_b_q),
    .done_o     (div_done),
    .result_o   (div_res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: begin
        if (div_go) begin
          state_d = S_DIV;
        end else if (finish) begin
          state_d = S_IDLE;
        end
      end
      S_DIV:  if (finish) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      top_out_q    <= top_res;
      depth_out_q  <= DEPTH_W'(count_d);
      status_out_q <= st;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.top_value = $signed(top_out_q);
  assign res_o.depth     = depth_out_q;
  assign res_o.status    = status_out_q;

  `RPN_ASSERT_IMP(a_cnt_bound, 1'b1, count_q <= FULL_CNT)
  `RPN_ASSERT_NEXT(a_cnt_hold, !finish, $stable(count_q))
  `RPN_ASSERT_NEXT(a_acc_exec, accept, state_q == S_EXEC)
  `RPN_ASSERT_IMP(a_wr_finish, wr_en, out_free && (state_q == S_EXEC || state_q == S_DIV))
  `RPN_ASSERT_IMP(a_div_busy, state_q == S_DIV, !req_i.ready && !div_start)

endmodule

`default_nettype wire

[verif/rpn_calc_checker.sv]
`default_nettype none

module rpn_calc_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rpn_cmd_if   cmd_mon_i,
  rpn_res_if   res_mon_i,
  output int   errors_o,
  output int   pending_o,
  output int   checked_o,
  output int   underflows_o,
  output int   overflows_o,
  output int   div_zeros_o,
  output int   peak_depth_o
);
  import rpn_pkg::*;

  typedef struct packed {
    word_t              top;
    logic [DEPTH_W-1:0] depth;
    status_e            status;
  } outcome_t;

  word_t       stack_mem [STACK_DEPTH];
  int unsigned stack_cnt;
  outcome_t    expected_q [$];
  outcome_t    want;
  outcome_t    predicted;
  int          errors;
  int          checked;
  int          underflows;
  int          overflows;
  int          div_zeros;
  int          peak_depth;

  function automatic word_t abs_word(input word_t x);
    return x[DATA_W-1] ? (~x + 1'b1) : x;
  endfunction

  // updates the stack copy and returns the result the core should report
  function automatic outcome_t apply_op(input cmd_e op, input word_t operand);
    outcome_t res;
    word_t    lhs;
    word_t    rhs;
    word_t    outv;
    res.status = ST_OK;
    case (op)
      CMD_PUSH, CMD_DUP: begin
        if (op == CMD_DUP && stack_cnt == 0) begin
          res.status = ST_UNF;
        end else if (stack_cnt >= STACK_DEPTH) begin
          res.status = ST_OVF;
        end else begin
          stack_mem[stack_cnt] = (op == CMD_PUSH) ? operand : stack_mem[stack_cnt-1];
          stack_cnt++;
        end
      end
      CMD_ABS: begin
        if (stack_cnt == 0) begin
          res.status = ST_UNF;
        end else begin
          stack_mem[stack_cnt-1] = abs_word(stack_mem[stack_cnt-1]);
        end
      end
      default: begin
        if (stack_cnt < 2) begin
          res.status = ST_UNF;
        end else begin
          lhs = stack_mem[stack_cnt-2];
          rhs = stack_mem[stack_cnt-1];
          if ((op == CMD_DIV || op == CMD_MOD) && rhs == '0) begin
            res.status = ST_DIVZ;
          end else begin
            case (op)
              CMD_ADD: outv = lhs + rhs;
              CMD_SUB: outv = lhs - rhs;
              CMD_MUL: outv = lhs * rhs;
              CMD_DIV: begin
                outv = abs_word(lhs) / abs_word(rhs);
                if (lhs[DATA_W-1] ^ rhs[DATA_W-1]) outv = ~outv + 1'b1;
              end
              CMD_MOD: begin
                outv = abs_word(lhs) % abs_word(rhs);
                if (lhs[DATA_W-1]) outv = ~outv + 1'b1;
              end
              default: outv = '0;
            endcase
            stack_mem[stack_cnt-2] = outv;
            stack_cnt--;
          end
        end
      end
    endcase
    res.top   = (stack_cnt == 0) ? '0 : stack_mem[stack_cnt-1];
    res.depth = DEPTH_W'(stack_cnt);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_cnt = 0;
      expected_q.delete();
      errors     = 0;
      checked    = 0;
      underflows = 0;
      overflows  = 0;
      div_zeros  = 0;
      peak_depth = 0;
    end else begin
      // result first: it always belongs to an earlier item
      if (res_mon_i.valid && res_mon_i.ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing pending: top %h depth %0d status %0d",
                   $time, res_mon_i.top_value, res_mon_i.depth, res_mon_i.status);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (res_mon_i.top_value !== want.top) begin
            errors++;
            $display("%0t: top_value mismatch: expected %h, got %h",
                     $time, want.top, res_mon_i.top_value);
          end
          if (res_mon_i.depth !== want.depth) begin
            errors++;
            $display("%0t: depth mismatch: expected %0d, got %0d",
                     $time, want.depth, res_mon_i.depth);
          end
          if (res_mon_i.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, res_mon_i.status);
          end
        end
      end
      if (cmd_mon_i.valid && cmd_mon_i.ready) begin
        predicted = apply_op(cmd_e'(cmd_mon_i.cmd), word_t'(cmd_mon_i.value));
        expected_q.insert(expected_q.size(), predicted);
        case (predicted.status)
          ST_UNF:  underflows++;
          ST_OVF:  overflows++;
          ST_DIVZ: div_zeros++;
          default: ;
        endcase
        if (stack_cnt > peak_depth) peak_depth = stack_cnt;
      end
    end
    errors_o     <= errors;
    pending_o    <= expected_q.size();
    checked_o    <= checked;
    underflows_o <= underflows;
    overflows_o  <= overflows;
    div_zeros_o  <= div_zeros;
    peak_depth_o <= peak_depth;
  end

endmodule

`default_nettype wire

[verif/tb_rpn_stack_calculator_core.sv]
`default_nettype none

module tb_rpn_stack_calculator_core;
  import rpn_pkg::*;

  localparam int    CYCLE_LIMIT  = 400000;
  localparam int    PHASE_ITEMS  = 175;
  localparam int    DRAIN_CYCLES = 80;
  localparam word_t WORD_MIN     = 32'h8000_0000;
  localparam word_t WORD_MAX     = 32'h7FFF_FFFF;
  localparam word_t WORD_NEG1    = 32'hFFFF_FFFF;

  typedef enum int {SEG_MIXED, SEG_FILL, SEG_DRAIN, SEG_NOISE} seg_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   cycles = 0;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   items_sent;

  int   errors;
  int   pending;
  int   checked;
  int   underflows;
  int   overflows;
  int   div_zeros;
  int   peak_depth;

  rpn_cmd_if req_if ();
  rpn_res_if res_if ();

  rpn_stack_calculator_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  rpn_calc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_mon_i    (req_if),
    .res_mon_i    (res_if),
    .errors_o     (errors),
    .pending_o    (pending),
    .checked_o    (checked),
    .underflows_o (underflows),
    .overflows_o  (overflows),
    .div_zeros_o  (div_zeros),
    .peak_depth_o (peak_depth)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, pending);
      $display("tb_rpn_stack_calculator_core: FAIL");
      $finish;
    end
  end

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= rst_ni && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // valid stays high across back-to-back items
  task automatic send_item(input cmd_e op, input word_t v);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      req_if.cmd   <= cmd_e'($urandom_range(7));
      req_if.value <= $urandom;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.cmd   <= op;
    req_if.value <= v;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
  endtask

  function automatic word_t pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 25) begin
      case ($urandom_range(6))
        0:       return '0;
        1:       return 32'd1;
        2:       return WORD_NEG1;
        3:       return WORD_MIN;
        4:       return WORD_MAX;
        5:       return 32'd2;
        default: return 32'hFFFF_FFFE;
      endcase
    end
    if (r < 60) return word_t'($urandom_range(40)) - 32'd20;
    return $urandom;
  endfunction

  task automatic run_directed();
    send_item(CMD_ABS,  '0);
    send_item(CMD_DUP,  WORD_NEG1);
    send_item(CMD_MOD,  '0);
    send_item(CMD_PUSH, WORD_MIN);
    send_item(CMD_ADD,  '0);
    send_item(CMD_ABS,  '0);
    send_item(CMD_PUSH, WORD_NEG1);
    send_item(CMD_DIV,  '0);
    send_item(CMD_PUSH, WORD_NEG1);
    send_item(CMD_MOD,  '0);
    send_item(CMD_PUSH, '0);
    send_item(CMD_DIV,  '0);
    send_item(CMD_MOD,  '0);
    send_item(CMD_SUB,  '0);
    send_item(CMD_PUSH, WORD_MAX);
    send_item(CMD_PUSH, 32'd1);
    send_item(CMD_ADD,  WORD_NEG1);
    send_item(CMD_DUP,  '0);
    send_item(CMD_MUL,  '0);
    send_item(CMD_PUSH, 32'hFFFF_FFF9);
    send_item(CMD_PUSH, 32'd2);
    send_item(CMD_DIV,  '0);
    send_item(CMD_PUSH, 32'd2);
    send_item(CMD_MOD,  '0);
    send_item(CMD_PUSH, 32'd5);
    send_item(CMD_SUB,  '0);
    send_item(CMD_ABS,  '0);
  endtask

  // segments: mixed traffic, fill past full, drain with two-operand ops, raw noise
  task automatic run_random(input int n_items);
    int   sent;
    int   seg_len;
    int   r;
    bit   first;
    seg_e kind;
    cmd_e op;
    sent  = 0;
    first = 1'b1;
    while (sent < n_items) begin
      r = $urandom_range(9);
      if (first)       kind = SEG_FILL;
      else if (r < 5)  kind = SEG_MIXED;
      else if (r < 7)  kind = SEG_FILL;
      else if (r < 9)  kind = SEG_DRAIN;
      else             kind = SEG_NOISE;
      first = 1'b0;
      case (kind)
        SEG_FILL:  seg_len = $urandom_range(72, 66);
        SEG_DRAIN: seg_len = $urandom_range(70, 10);
        SEG_NOISE: seg_len = $urandom_range(15, 5);
        default:   seg_len = $urandom_range(30, 10);
      endcase
      if (seg_len > n_items - sent) seg_len = n_items - sent;
      repeat (seg_len) begin
        r = $urandom_range(99);
        case (kind)
          SEG_FILL:  op = (r < 80) ? CMD_PUSH : CMD_DUP;
          SEG_DRAIN: op = cmd_e'($urandom_range(int'(CMD_MOD), int'(CMD_ADD)));
          SEG_NOISE: op = cmd_e'($urandom_range(7));
          default: begin
            if (r < 35)      op = CMD_PUSH;
            else if (r < 43) op = CMD_DUP;
            else if (r < 50) op = CMD_ABS;
            else if (r < 58) op = CMD_ADD;
            else if (r < 66) op = CMD_SUB;
            else if (r < 74) op = CMD_MUL;
            else if (r < 87) op = CMD_DIV;
            else             op = CMD_MOD;
          end
        endcase
        send_item(op, (kind == SEG_NOISE) ? word_t'($urandom) : pick_value());
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.cmd   <= CMD_PUSH;
    req_if.value <= '0;
    items_sent    = 0;
    src_idle_pct  = 9;
    sink_idle_pct = 71;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(PHASE_ITEMS);
    src_idle_pct  = 71;
    sink_idle_pct = 9;
    run_random(PHASE_ITEMS);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(PHASE_ITEMS);
    req_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items through three back-pressure phases, %0d results checked.",
             items_sent, checked);
    $display("Fault statuses: %0d underflow, %0d overflow, %0d divide by zero; peak depth %0d.",
             underflows, overflows, div_zeros, peak_depth);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("tb_rpn_stack_calculator_core: PASS");
    end else begin
      $display("tb_rpn_stack_calculator_core: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
